// File: design/pis_pkg.sv
// shared types, constants and saturation helper for the penalized stress block
package pis_pkg;

  localparam int DATA_W   = 32;
  localparam int N_FIELDS = 6;
  localparam int TDATA_W  = DATA_W * N_FIELDS;

  // register indexes
  localparam logic [1:0] REG_YOUNGS  = 2'd0;
  localparam logic [1:0] REG_POISSON = 2'd1;
  localparam logic [1:0] REG_PENALTY = 2'd2;
  localparam logic [1:0] REG_DENSITY = 2'd3;

  localparam int CFG_W = 31;

  // widths of derived coefficients
  localparam int A_W  = 17;
  localparam int B_W  = 15;
  localparam int DP_W = 47;
  localparam int GP_W = 31;
  localparam int MAG_W = 63;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [16:0] EPS_Q16 = 17'd66;

  typedef struct packed {
    logic            ready;
    logic [A_W-1:0]  a;
    logic [B_W-1:0]  b;
    logic [DP_W-1:0] dp;
    logic [GP_W-1:0] gp;
  } pis_coef_t;

  localparam logic [MAG_W-1:0] LIM_POS = (MAG_W'(1) << (DATA_W - 1)) - MAG_W'(1);
  localparam logic [MAG_W-1:0] LIM_NEG = MAG_W'(1) << (DATA_W - 1);

  // apply sign to a magnitude and clamp to the signed output range
  function automatic logic [DATA_W-1:0] sat_out(input logic [MAG_W-1:0] mag, input logic neg);
    logic [MAG_W-1:0] m;
    begin
      m = mag;
      if (neg) begin
        if (m > LIM_NEG) m = LIM_NEG;
        sat_out = DATA_W'(MAG_W'(0) - m);
      end else begin
        if (m > LIM_POS) m = LIM_POS;
        sat_out = DATA_W'(m);
      end
    end
  endfunction

endpackage

// File: design/penalized_isotropic_stress.sv
// Stress of a RAMP-penalized 3D isotropic material from a strain vector.
// Throughput: one item per cycle while the output is not stalled; the
// five stages are set by the split 47x48 multiply and the final clamp.
// Coefficient unit recomputes D, G, p serially after reset and after each
// config write; s_tready stays low meanwhile. Reset is synchronous and
// empties the pipeline.
module penalized_isotropic_stress (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // strain_xx, strain_yy, strain_zz, strain_yz, strain_xz, strain_xy
  input  logic [pis_pkg::TDATA_W-1:0] s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // stress_xx, stress_yy, stress_zz, stress_yz, stress_xz, stress_xy
  output logic [pis_pkg::TDATA_W-1:0] m_tdata,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [pis_pkg::CFG_W-1:0]   cfg_data
);
  import pis_pkg::*;

  pis_coef_t coef;

  pis_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  logic adv;
  logic v1, v2, v3, v4, v5;

  logic signed [DATA_W-1:0] st [N_FIELDS];
  logic signed [17:0] a_s;
  logic signed [15:0] b_s;

  // stage 1 registers
  logic signed [49:0] s1_pa [3];
  logic signed [48:0] s1_pb [3];
  logic        [31:0] s1_sm [3];
  logic               s1_sn [3];
  // stage 2 registers
  logic        [47:0] s2_tm [3];
  logic               s2_tn [3];
  logic        [31:0] s2_sm [3];
  logic               s2_sn [3];
  // stage 3 registers
  logic        [47:0] s3_ll [3];
  logic        [47:0] s3_lh [3];
  logic        [46:0] s3_hl [3];
  logic        [46:0] s3_hh [3];
  logic               s3_tn [3];
  logic        [62:0] s3_sp [3];
  logic               s3_sn [3];
  // stage 4 registers
  logic        [MAG_W-1:0] s4_tm [3];
  logic                    s4_tn [3];
  logic        [46:0]      s4_sm [3];
  logic                    s4_sn [3];

  // stall: every stage moves when the output register is free or taken
  assign adv      = !v5 || m_tready;
  assign s_tready = adv && coef.ready;
  assign m_tvalid = v5;

  assign a_s = signed'({1'b0, coef.a});
  assign b_s = signed'({1'b0, coef.b});

  always_comb begin
    for (int i = 0; i < N_FIELDS; i++) begin
      st[i] = signed'(s_tdata[i*DATA_W +: DATA_W]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid && s_tready;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // stages 1 to 5
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [50:0] t;
        logic        [50:0] tabs;
        logic        [95:0] sum;
        // stage 1: weighted normal terms, shear magnitude
        s1_pa[i] <= a_s * st[i];
        s1_pb[i] <= b_s * (33'(st[(i+1)%3]) + 33'(st[(i+2)%3]));
        s1_sn[i] <= st[i+3][DATA_W-1];
        s1_sm[i] <= st[i+3][DATA_W-1] ? 32'(-33'(st[i+3])) : 32'(st[i+3]);
        // stage 2: combine normal terms, sign and magnitude
        t    = 51'(s1_pa[i]) + 51'(s1_pb[i]);
        tabs = t[50] ? 51'(-t) : 51'(t);
        s2_tn[i] <= t[50];
        s2_tm[i] <= tabs[47:0];
        s2_sn[i] <= s1_sn[i];
        s2_sm[i] <= s1_sm[i];
        // stage 3: partial products
        s3_ll[i] <= 48'(coef.dp[23:0]) * 48'(s2_tm[i][23:0]);
        s3_lh[i] <= 48'(coef.dp[23:0]) * 48'(s2_tm[i][47:24]);
        s3_hl[i] <= 47'(coef.dp[46:24]) * 47'(s2_tm[i][23:0]);
        s3_hh[i] <= 47'(coef.dp[46:24]) * 47'(s2_tm[i][47:24]);
        s3_tn[i] <= s2_tn[i];
        s3_sp[i] <= 63'(coef.gp) * 63'(s2_sm[i]);
        s3_sn[i] <= s2_sn[i];
        // stage 4: sum partial products and scale
        sum = 96'(s3_ll[i]) + (96'(49'(s3_lh[i]) + 49'(s3_hl[i])) << 24)
            + (96'(s3_hh[i]) << 48);
        s4_tm[i] <= sum[94:32];
        s4_tn[i] <= s3_tn[i];
        s4_sm[i] <= s3_sp[i][62:16];
        s4_sn[i] <= s3_sn[i];
        // stage 5: clamp into the output register
        m_tdata[i*DATA_W +: DATA_W]     <= sat_out(s4_tm[i], s4_tn[i]);
        m_tdata[(i+3)*DATA_W +: DATA_W] <= sat_out(MAG_W'(s4_sm[i]), s4_sn[i]);
      end
    end
  end

endmodule

// File: design/pis_coef.sv
// configuration registers and sequential unit that derives the stiffness factors
module pis_coef (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [pis_pkg::CFG_W-1:0] cfg_data,
  output pis_pkg::pis_coef_t       coef
);
  import pis_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_DIV_D = 3'd2;
  localparam logic [2:0] ST_DIV_G = 3'd3;
  localparam logic [2:0] ST_DIV_P = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;

  logic [2:0]  state;
  logic [30:0] e_r;
  logic [14:0] nu_r;
  logic [23:0] q_r;
  logic [16:0] rho_r;

  logic [63:0] num;
  logic [40:0] den;
  logic [40:0] rem;
  logic [63:0] quo;
  logic [5:0]  cnt;

  logic [45:0] dmod;
  logic [29:0] gmod;
  logic [16:0] pen;
  logic [62:0] md;
  logic [46:0] mg;
  logic [62:0] acc_d;
  logic [46:0] acc_g;
  logic [46:0] dp;
  logic [30:0] gp;

  logic [16:0] rho_c;
  logic [33:0] den1;
  logic [40:0] den2;
  logic [41:0] rem_sh;
  logic        ge;
  logic [40:0] rem_next;
  logic [63:0] quo_next;
  logic [62:0] acc_d_next;
  logic [46:0] acc_g_next;

  // denominators from the registers
  always_comb begin
    rho_c = (rho_r > ONE_Q16) ? ONE_Q16 : rho_r;
    den1  = 34'(ONE_Q16 + 17'(nu_r)) * 34'(ONE_Q16 - 17'({nu_r, 1'b0}));
    den2  = (41'(1) << 32) + 41'(q_r) * 41'(ONE_Q16 - rho_c);
  end

  // one restoring division step
  always_comb begin
    rem_sh   = {rem, num[63]};
    ge       = rem_sh >= {1'b0, den};
    rem_next = ge ? 41'(rem_sh - {1'b0, den}) : rem_sh[40:0];
    quo_next = {quo[62:0], ge};
  end

  // one shift-add multiply step
  always_comb begin
    acc_d_next = pen[0] ? acc_d + md : acc_d;
    acc_g_next = pen[0] ? acc_g + mg : acc_g;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      e_r   <= 31'd65536;
      nu_r  <= 15'd19661;
      q_r   <= 24'd327680;
      rho_r <= 17'd62259;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_YOUNGS:  e_r   <= cfg_data;
        REG_POISSON: nu_r  <= cfg_data[14:0];
        REG_PENALTY: q_r   <= cfg_data[23:0];
        REG_DENSITY: rho_r <= cfg_data[16:0];
        default: ;
      endcase
      state <= ST_LOAD;
    end else begin
      case (state)
        ST_LOAD: state <= ST_DIV_D;
        ST_DIV_D: if (cnt == 6'd63) state <= ST_DIV_G;
        ST_DIV_G: if (cnt == 6'd63) state <= ST_DIV_P;
        ST_DIV_P: if (cnt == 6'd63) state <= ST_MUL;
        ST_MUL:   if (cnt == 6'd16) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // datapath of the sequencer
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        num <= {1'b0, e_r, 32'd0};
        den <= 41'(den1);
        rem <= '0;
        cnt <= '0;
      end
      ST_DIV_D, ST_DIV_G, ST_DIV_P: begin
        rem <= rem_next;
        quo <= quo_next;
        num <= {num[62:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          rem <= '0;
          cnt <= '0;
          if (state == ST_DIV_D) begin
            dmod <= quo_next[45:0];
            num  <= {17'd0, e_r, 16'd0};
            den  <= 41'({ONE_Q16 + 17'(nu_r), 1'b0});
          end else if (state == ST_DIV_G) begin
            gmod <= quo_next[29:0];
            num  <= {15'd0, rho_c, 32'd0};
            den  <= den2;
          end else begin
            pen   <= quo_next[16:0] + EPS_Q16;
            md    <= {17'd0, dmod};
            mg    <= {17'd0, gmod};
            acc_d <= '0;
            acc_g <= '0;
          end
        end
      end
      ST_MUL: begin
        acc_d <= acc_d_next;
        acc_g <= acc_g_next;
        pen   <= {1'b0, pen[16:1]};
        md    <= {md[61:0], 1'b0};
        mg    <= {mg[45:0], 1'b0};
        cnt   <= cnt + 6'd1;
        if (cnt == 6'd16) begin
          dp <= acc_d_next[62:16];
          gp <= acc_g_next[46:16];
        end
      end
      default: ;
    endcase
  end

  assign coef.ready = (state == ST_IDLE);
  assign coef.a     = ONE_Q16 - 17'(nu_r);
  assign coef.b     = nu_r;
  assign coef.dp    = dp;
  assign coef.gp    = gp;

endmodule
